### sv/csq_pkg.sv
// csq_pkg: shared types and codes for the counting semaphore wait queue
// used by the channel interfaces and the top level; no dependencies
package csq_pkg;

	localparam int CMD_W    = 2;
	localparam int ID_W     = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 16;
	localparam int WAIT_W   = 5;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [COUNT_W-1:0]  count_t;

	// command codes
	localparam cmd_t CMD_DOWN   = 2'd0;
	localparam cmd_t CMD_TRY    = 2'd1;
	localparam cmd_t CMD_UP     = 2'd2;
	localparam cmd_t CMD_CANCEL = 2'd3;

	// result status codes
	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_QUEUED      = 3'd1;
	localparam status_t ST_UNAVAIL     = 3'd2;
	localparam status_t ST_REMOVED     = 3'd3;
	localparam status_t ST_NOT_WAITING = 3'd4;
	localparam status_t ST_FULL        = 3'd5;
	localparam status_t ST_SATURATED   = 3'd6;

	localparam count_t COUNT_MAX   = 16'hFFFF;
	localparam count_t COUNT_RESET = 16'd1;

endpackage

### sv/csq_ifs.sv
// csq_ifs: valid/ready channel interfaces for command and result beats
// depends on csq_pkg
interface csq_req_if;
	logic                 valid;
	logic                 ready;
	csq_pkg::cmd_t        cmd;
	logic [csq_pkg::ID_W-1:0] requester_id;

	modport source (output valid, output cmd, output requester_id, input ready);
	modport sink   (input valid, input cmd, input requester_id, output ready);
endinterface

interface csq_rsp_if;
	logic                       valid;
	logic                       ready;
	csq_pkg::status_t           status;
	logic                       woken_valid;
	logic [csq_pkg::ID_W-1:0]   woken_id;
	csq_pkg::count_t            count_now;
	logic [csq_pkg::WAIT_W-1:0] waiters_now;

	modport source (output valid, output status, output woken_valid, output woken_id,
		output count_now, output waiters_now, input ready);
	modport sink   (input valid, input status, input woken_valid, input woken_id,
		input count_now, input waiters_now, output ready);
endinterface

### sv/counting_semaphore_wait_queue.sv
// counting_semaphore_wait_queue: counting semaphore with a fifo of waiting ids
// depends on csq_pkg and the interfaces in csq_ifs
//
//  channel   kind         beat contents
//  req       valid/ready  cmd, requester_id
//  rsp       valid/ready  status, woken_valid, woken_id, count_now, waiters_now
//  apb       psel/penable initial_count at byte address 0
//
// down, try-down, up with no waiter, cancel on empty queue: answered from idle
// up with a waiter: S_WAKE, S_DONE (head entry read through the ram read port)
// cancel with waiters: S_CMP reads one entry per step while searching, S_MOVE
//   moves each entry behind the removed one toward the head, then S_DONE
// arst_n clears count to 1 and the queue to empty; ram contents need no reset
// a waiting rsp beat holds off every new command until the beat is taken
module counting_semaphore_wait_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	csq_req_if.sink                  req,
	csq_rsp_if.source                rsp,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	// stored id width: ids wider than the port carry no extra bits
	localparam int IdW   = (ID_BITS < csq_pkg::ID_W) ? ID_BITS : csq_pkg::ID_W;
	localparam int HeadW = $clog2(QUEUE_DEPTH);
	localparam int OccW  = $clog2(QUEUE_DEPTH + 1);
	localparam int SumW  = OccW + 2;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WAKE = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_MOVE = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]            state_q, state_d;
	csq_pkg::count_t       init_q;
	csq_pkg::count_t       count_q, count_d;
	logic [HeadW-1:0]      head_q, head_d;
	logic [OccW-1:0]       occ_q, occ_d;
	logic [OccW-1:0]       idx_q, idx_d;
	logic [IdW-1:0]        id_q;

	// wait queue ram, one write port and one read port
	logic [IdW-1:0]        mem_q [QUEUE_DEPTH];
	logic [IdW-1:0]        rdata_q;
	logic                  mem_we, mem_re;
	logic [HeadW-1:0]      mem_wa, mem_ra;
	logic [IdW-1:0]        mem_wd;

	// result held between the end of a long command and the output register
	csq_pkg::status_t      pend_status_q, pend_status_d;
	logic                  pend_wv_q, pend_wv_d;
	logic [IdW-1:0]        pend_wid_q, pend_wid_d;

	// output register
	logic                  res_v_q;
	csq_pkg::status_t      res_status_q;
	logic                  res_wv_q;
	logic [IdW-1:0]        res_wid_q;
	csq_pkg::count_t       res_count_q;
	logic [OccW-1:0]       res_occ_q;

	logic                  load_res;
	csq_pkg::status_t      ld_status;
	logic                  ld_wv;
	logic [IdW-1:0]        ld_wid;

	logic                  out_free;
	logic                  ready_c;
	logic                  cfg_we;
	logic [IdW-1:0]        id_in;
	logic [OccW:0]         occ_x, idx_p1, idx_p2;
	logic                  match, more;

	// ring position of the entry off places behind the head
	function automatic logic [HeadW-1:0] slot_of(input logic [HeadW-1:0] head,
		input logic [OccW:0] off);
		logic [SumW-1:0] sum;
		sum = SumW'(head) + SumW'(off);
		if (sum >= SumW'(QUEUE_DEPTH)) begin
			sum = sum - SumW'(QUEUE_DEPTH);
		end
		return sum[HeadW-1:0];
	endfunction

	assign out_free = !res_v_q || rsp.ready;
	assign ready_c  = (state_q == S_IDLE) && out_free;
	assign req.ready = ready_c;
	assign id_in    = req.requester_id[IdW-1:0];
	assign occ_x    = {1'b0, occ_q};
	assign idx_p1   = {1'b0, idx_q} + (OccW+1)'(1);
	assign idx_p2   = {1'b0, idx_q} + (OccW+1)'(2);
	assign match    = (rdata_q == id_q);
	assign more     = (idx_p1 < occ_x);

	// register port: only initial_count, at index 0
	assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'b0, init_q} : 32'b0;

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		occ_d         = occ_q;
		head_d        = head_q;
		idx_d         = idx_q;
		mem_we        = 1'b0;
		mem_wa        = '0;
		mem_wd        = '0;
		mem_re        = 1'b0;
		mem_ra        = '0;
		load_res      = 1'b0;
		ld_status     = csq_pkg::ST_OK;
		ld_wv         = 1'b0;
		ld_wid        = '0;
		pend_status_d = pend_status_q;
		pend_wv_d     = pend_wv_q;
		pend_wid_d    = pend_wid_q;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid && ready_c) begin
					unique case (req.cmd)
						csq_pkg::CMD_DOWN: begin
							load_res = 1'b1;
							if (count_q != '0) begin
								count_d = count_q - 16'd1;
							end else if (occ_q == OccW'(QUEUE_DEPTH)) begin
								ld_status = csq_pkg::ST_FULL;
							end else begin
								// append at the tail
								mem_we    = 1'b1;
								mem_wa    = slot_of(head_q, occ_x);
								mem_wd    = id_in;
								occ_d     = occ_q + OccW'(1);
								ld_status = csq_pkg::ST_QUEUED;
							end
						end
						csq_pkg::CMD_TRY: begin
							load_res = 1'b1;
							if (count_q != '0) begin
								count_d = count_q - 16'd1;
							end else begin
								ld_status = csq_pkg::ST_UNAVAIL;
							end
						end
						csq_pkg::CMD_UP: begin
							if (occ_q != '0) begin
								// fetch the oldest waiter
								mem_re  = 1'b1;
								mem_ra  = head_q;
								state_d = S_WAKE;
							end else if (count_q == csq_pkg::COUNT_MAX) begin
								load_res  = 1'b1;
								ld_status = csq_pkg::ST_SATURATED;
							end else begin
								load_res = 1'b1;
								count_d  = count_q + 16'd1;
							end
						end
						csq_pkg::CMD_CANCEL: begin
							if (occ_q == '0) begin
								load_res  = 1'b1;
								ld_status = csq_pkg::ST_NOT_WAITING;
							end else begin
								// start the search at the head
								idx_d   = '0;
								mem_re  = 1'b1;
								mem_ra  = head_q;
								state_d = S_CMP;
							end
						end
					endcase
				end
			end
			S_WAKE: begin
				pend_status_d = csq_pkg::ST_OK;
				pend_wv_d     = 1'b1;
				pend_wid_d    = rdata_q;
				head_d        = slot_of(head_q, (OccW+1)'(1));
				occ_d         = occ_q - OccW'(1);
				state_d       = S_DONE;
			end
			S_CMP: begin
				if (match && more) begin
					// close the gap, first entry behind the match
					mem_re  = 1'b1;
					mem_ra  = slot_of(head_q, idx_p1);
					state_d = S_MOVE;
				end else if (match) begin
					occ_d         = occ_q - OccW'(1);
					pend_status_d = csq_pkg::ST_REMOVED;
					pend_wv_d     = 1'b0;
					pend_wid_d    = '0;
					state_d       = S_DONE;
				end else if (more) begin
					idx_d  = idx_p1[OccW-1:0];
					mem_re = 1'b1;
					mem_ra = slot_of(head_q, idx_p1);
				end else begin
					pend_status_d = csq_pkg::ST_NOT_WAITING;
					pend_wv_d     = 1'b0;
					pend_wid_d    = '0;
					state_d       = S_DONE;
				end
			end
			S_MOVE: begin
				// rdata holds entry idx+1, it moves one place toward the head
				mem_we = 1'b1;
				mem_wa = slot_of(head_q, {1'b0, idx_q});
				mem_wd = rdata_q;
				idx_d  = idx_p1[OccW-1:0];
				if (idx_p2 < occ_x) begin
					mem_re = 1'b1;
					mem_ra = slot_of(head_q, idx_p2);
				end else begin
					occ_d         = occ_q - OccW'(1);
					pend_status_d = csq_pkg::ST_REMOVED;
					pend_wv_d     = 1'b0;
					pend_wid_d    = '0;
					state_d       = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					load_res  = 1'b1;
					ld_status = pend_status_q;
					ld_wv     = pend_wv_q;
					ld_wid    = pend_wid_q;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			init_q  <= csq_pkg::COUNT_RESET;
			count_q <= csq_pkg::COUNT_RESET;
			head_q  <= '0;
			occ_q   <= '0;
			idx_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			occ_q   <= occ_d;
			idx_q   <= idx_d;
			if (cfg_we) begin
				init_q  <= pwdata[15:0];
				count_q <= pwdata[15:0];
			end else begin
				count_q <= count_d;
			end
			if (load_res) begin
				res_v_q <= 1'b1;
			end else if (rsp.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && ready_c) begin
			id_q <= id_in;
		end
		pend_status_q <= pend_status_d;
		pend_wv_q     <= pend_wv_d;
		pend_wid_q    <= pend_wid_d;
		if (load_res) begin
			res_status_q <= ld_status;
			res_wv_q     <= ld_wv;
			res_wid_q    <= ld_wid;
			res_count_q  <= count_d;
			res_occ_q    <= occ_d;
		end
	end

	// queue ram
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_ra];
		end
	end

	assign rsp.valid       = res_v_q;
	assign rsp.status      = res_status_q;
	assign rsp.woken_valid = res_wv_q;
	assign rsp.woken_id    = csq_pkg::ID_W'(res_wid_q);
	assign rsp.count_now   = res_count_q;
	assign rsp.waiters_now = csq_pkg::WAIT_W'(res_occ_q);

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for counting_semaphore_wait_queue
// needs csq_pkg, the csq_ifs channel interfaces and the rtl top level
// a semaphore model predicts every result beat, checked field by field
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int WAIT_DEPTH    = 16;
	localparam int STALL_LIMIT   = 5000;  // cycles with no beat on either channel
	localparam int DRAIN_CYCLES  = 40;
	localparam int CHUNK_ITEMS   = 40;

	// register map: initial_count is the only register, byte address 4 decodes to nothing
	localparam logic [2:0] ADDR_INITIAL_COUNT = 3'd0;
	localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;

	// traffic shapes for the random chunks
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

	typedef logic [csq_pkg::ID_W-1:0]   req_id_t;
	typedef logic [csq_pkg::WAIT_W-1:0] waiters_t;

	typedef struct packed {
		csq_pkg::status_t status;
		logic             woken_valid;
		req_id_t          woken_id;
		csq_pkg::count_t  count_now;
		waiters_t         waiters_now;
	} sem_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	csq_req_if req_ch();
	csq_rsp_if rsp_ch();

	counting_semaphore_wait_queue #(
		.QUEUE_DEPTH(WAIT_DEPTH),
		.ID_BITS(csq_pkg::ID_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// semaphore model state: register, unit count and the ids still waiting, oldest first
	csq_pkg::count_t sem_initial;
	csq_pkg::count_t sem_count;
	req_id_t     waiter_ids[$];
	// results owed by the block, oldest first
	sem_result_t owed_results[$];

	int mismatches   = 0;
	int quiet_cycles = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;

	// apply one command to the model and return the result beat it must produce
	function automatic sem_result_t apply_command(csq_pkg::cmd_t cmd, req_id_t id);
		sem_result_t r;
		int hit;
		r = '0;
		hit = -1;
		case (cmd)
			csq_pkg::CMD_DOWN: begin
				if (sem_count != 0)
					sem_count--;
				else if (waiter_ids.size() >= WAIT_DEPTH)
					r.status = csq_pkg::ST_FULL;
				else begin
					waiter_ids.push_back(id);
					r.status = csq_pkg::ST_QUEUED;
				end
			end
			csq_pkg::CMD_TRY: begin
				if (sem_count != 0)
					sem_count--;
				else
					r.status = csq_pkg::ST_UNAVAIL;
			end
			csq_pkg::CMD_UP: begin
				// a waiter takes the unit directly, the count is left alone
				if (waiter_ids.size() != 0) begin
					r.woken_valid = 1'b1;
					r.woken_id = waiter_ids.pop_front();
				end else if (sem_count == csq_pkg::COUNT_MAX)
					r.status = csq_pkg::ST_SATURATED;
				else
					sem_count++;
			end
			csq_pkg::CMD_CANCEL: begin
				// only the oldest matching entry goes, younger ones close the gap
				foreach (waiter_ids[i])
					if (hit < 0 && waiter_ids[i] == id)
						hit = i;
				if (hit >= 0) begin
					waiter_ids.delete(hit);
					r.status = csq_pkg::ST_REMOVED;
				end else
					r.status = csq_pkg::ST_NOT_WAITING;
			end
		endcase
		r.count_now = sem_count;
		r.waiters_now = csq_pkg::WAIT_W'(waiter_ids.size());
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0h actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	// command beats update the model as they are accepted, result beats are
	// checked against the oldest owed result; one block keeps the order fixed
	always @(posedge clk) begin : track_beats
		sem_result_t due;
		if (req_ch.valid && req_ch.ready)
			owed_results.push_back(apply_command(req_ch.cmd, req_ch.requester_id));
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (owed_results.size() == 0) begin
				$error("result beat with no command outstanding");
				mismatches++;
			end else begin
				due = owed_results.pop_front();
				check_field("status", 32'(due.status), 32'(rsp_ch.status));
				check_field("woken_valid", 32'(due.woken_valid), 32'(rsp_ch.woken_valid));
				check_field("woken_id", 32'(due.woken_id), 32'(rsp_ch.woken_id));
				check_field("count_now", 32'(due.count_now), 32'(rsp_ch.count_now));
				check_field("waiters_now", 32'(due.waiters_now), 32'(rsp_ch.waiters_now));
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

	// watchdog: too long without a beat on either channel means a hang
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles == STALL_LIMIT) begin
			$display("counting_semaphore_wait_queue verification failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// one command beat; random sender gaps carry junk payload with valid low
	task automatic send_cmd(csq_pkg::cmd_t cmd, req_id_t id);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= csq_pkg::cmd_t'($urandom_range(3));
			req_ch.requester_id <= req_id_t'($urandom);
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.requester_id <= id;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// stop sending and wait until every owed result has come back
	task automatic wait_until_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// apb: setup cycle, then access cycle until pready; the bus is released after
	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
		output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// only while idle: write a register, mirror it in the model, read initial_count back
	task automatic write_register(logic [2:0] addr, logic [31:0] value);
		logic [31:0] rdata;
		apb_access(1'b1, addr, value, rdata);
		if (addr == ADDR_INITIAL_COUNT) begin
			sem_initial = value[csq_pkg::COUNT_W-1:0];
			sem_count = value[csq_pkg::COUNT_W-1:0];
		end
		apb_access(1'b0, ADDR_INITIAL_COUNT, '0, rdata);
		check_field("initial_count readback", 32'(sem_initial),
			32'(rdata[csq_pkg::COUNT_W-1:0]));
	endtask

	// reset count of one: take it, miss it, cancel on an empty queue, give it back
	task automatic test_semaphore_basics();
		send_cmd(csq_pkg::CMD_TRY, 8'h00);
		send_cmd(csq_pkg::CMD_TRY, 8'hFF);
		send_cmd(csq_pkg::CMD_CANCEL, 8'h5A);
		send_cmd(csq_pkg::CMD_UP, 8'h00);
	endtask

	// up with the count at its ceiling and nobody waiting is flagged, not wrapped
	task automatic test_count_saturation();
		wait_until_drained();
		write_register(ADDR_INITIAL_COUNT, 32'h0000_FFFF);
		send_cmd(csq_pkg::CMD_UP, 8'h81);
		send_cmd(csq_pkg::CMD_TRY, 8'h7E);
	endtask

	// a write outside the map must leave initial_count and the count untouched
	task automatic test_register_decode();
		wait_until_drained();
		write_register(ADDR_UNMAPPED, 32'h0000_0003);
		send_cmd(csq_pkg::CMD_TRY, 8'h42);
	endtask

	// fill the queue with a duplicate id, overflow it, cancel the older duplicate, wake head
	task automatic test_wait_queue_order();
		req_id_t fill_ids[WAIT_DEPTH];
		wait_until_drained();
		write_register(ADDR_INITIAL_COUNT, 32'h0);
		foreach (fill_ids[i])
			fill_ids[i] = req_id_t'($urandom);
		fill_ids[0] = 8'h00;
		fill_ids[1] = 8'hFF;
		fill_ids[2] = 8'h3C;
		fill_ids[3] = 8'h3C;
		foreach (fill_ids[i])
			send_cmd(csq_pkg::CMD_DOWN, fill_ids[i]);
		send_cmd(csq_pkg::CMD_DOWN, 8'h77);
		send_cmd(csq_pkg::CMD_CANCEL, 8'h3C);
		send_cmd(csq_pkg::CMD_UP, 8'h00);
	endtask

	// chunks of random traffic, each with a fill, drain or even command mix;
	// between chunks the count is sometimes reloaded, mostly small so waits happen
	task automatic test_random_traffic(int n_items, int src_pct, int sink_pct);
		int left;
		int chunk;
		int roll;
		traffic_mix_t mix;
		int down_lim;
		int try_lim;
		int up_lim;
		csq_pkg::cmd_t cmd;
		req_id_t id;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		left = n_items;
		while (left > 0) begin
			chunk = (left < CHUNK_ITEMS) ? left : CHUNK_ITEMS;
			left -= chunk;
			if ($urandom_range(2) == 0) begin
				wait_until_drained();
				case ($urandom_range(7))
					0: write_register(ADDR_INITIAL_COUNT, 32'd0);
					1: write_register(ADDR_INITIAL_COUNT, 32'd1);
					2: write_register(ADDR_INITIAL_COUNT, 32'd2);
					3: write_register(ADDR_INITIAL_COUNT, 32'd3);
					4: write_register(ADDR_INITIAL_COUNT, 32'(csq_pkg::COUNT_MAX));
					5: write_register(ADDR_INITIAL_COUNT, 32'(csq_pkg::COUNT_MAX) - 32'd1);
					6: write_register(ADDR_INITIAL_COUNT,
						$urandom_range(4, 32'(csq_pkg::COUNT_MAX)));
					default: write_register(ADDR_UNMAPPED, $urandom);
				endcase
			end
			mix = traffic_mix_t'($urandom_range(2));
			case (mix)
				MIX_FILL: begin
					down_lim = 50; try_lim = 60; up_lim = 75;
				end
				MIX_DRAIN: begin
					down_lim = 15; try_lim = 25; up_lim = 75;
				end
				default: begin
					down_lim = 30; try_lim = 45; up_lim = 75;
				end
			endcase
			repeat (chunk) begin
				roll = $urandom_range(99);
				if (roll < down_lim)
					cmd = csq_pkg::CMD_DOWN;
				else if (roll < try_lim)
					cmd = csq_pkg::CMD_TRY;
				else if (roll < up_lim)
					cmd = csq_pkg::CMD_UP;
				else
					cmd = csq_pkg::CMD_CANCEL;
				// cancels mostly aim at a queued id; the rest miss or hit by chance
				if (cmd == csq_pkg::CMD_CANCEL && waiter_ids.size() != 0 &&
					$urandom_range(3) != 0)
					id = waiter_ids[$urandom_range(waiter_ids.size() - 1)];
				else if ($urandom_range(1) == 0)
					id = req_id_t'($urandom_range(7));
				else
					id = req_id_t'($urandom_range(255));
				send_cmd(cmd, id);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= csq_pkg::CMD_DOWN;
		req_ch.requester_id <= '0;
		sem_initial = csq_pkg::COUNT_RESET;
		sem_count = csq_pkg::COUNT_RESET;
		waiter_ids.delete();
		src_idle_pct = 19;
		sink_idle_pct = 79;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_semaphore_basics();
		test_count_saturation();
		test_register_decode();
		test_wait_queue_order();
		test_random_traffic(470, 19, 79);
		test_random_traffic(470, 79, 19);
		test_random_traffic(460, 0, 0);

		// everything sent: collect the last results, then look for strays
		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("counting_semaphore_wait_queue verification clean");
		else
			$display("counting_semaphore_wait_queue verification failed");
		$finish;
	end

endmodule
